/* design/gcd_pkg.sv */
package gcd_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int PIPE_DEPTH   = 6 + 2 * CORDIC_STEPS + 5 + SQRT_STEPS + 3;

  localparam int LAT_W   = 31;
  localparam int LON_W   = 32;
  localparam int RAD_W   = 23;
  localparam int RANGE_W = 33;
  localparam int DIN_W   = 128;
  localparam int DOUT_W  = 40;

  // Angle in 1e-7 degree, CORDIC datapath and angle accumulator widths.
  localparam int AW = 34;
  localparam int XW = 34;
  localparam int ZW = 34;

  localparam logic [RAD_W-1:0] RADIUS_RST = 23'd6371000;

  localparam logic signed [AW-1:0] TURN_E7    = 34'sd3600000000;
  localparam logic signed [AW-1:0] HALF_E7    = 34'sd1800000000;
  localparam logic signed [AW-1:0] QUARTER_E7 = 34'sd900000000;

  // Degrees to radians: z = floor((mag * ZK + ZBIAS) / (2^11 * DIVC)).
  localparam logic [31:0] ZK    = 32'd2698607541;
  localparam logic [61:0] ZBIAS = 62'd720000000;
  localparam logic [19:0] DIVC  = 20'd703125;
  localparam logic [31:0] RECIP = 32'((64'd1 << 51) / 64'd703125);
  localparam logic [22:0] DIVC1 = 23'(DIVC);
  localparam logic [22:0] DIVC2 = 23'(2 * DIVC);
  localparam logic [22:0] DIVC3 = 23'(3 * DIVC);
  localparam logic [22:0] DIVC4 = 23'(4 * DIVC);

  localparam logic signed [XW-1:0] GAIN_INV_Q30 = 34'sd652032874;
  localparam logic signed [31:0]   ONE_Q30      = 32'sd1073741824;
  localparam logic signed [ZW-1:0] PI_Q30       = 34'sd3373259426;
  localparam logic [60:0]          ONE_SQ       = 61'd1 << 60;
  localparam logic [RANGE_W-1:0]   RANGE_MAX    = '1;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0: a = 34'sd843314857;
      1: a = 34'sd497837829;
      2: a = 34'sd263043837;
      3: a = 34'sd133525159;
      4: a = 34'sd67021687;
      5: a = 34'sd33543516;
      6: a = 34'sd16775851;
      7: a = 34'sd8388437;
      8: a = 34'sd4194283;
      9: a = 34'sd2097149;
      default: begin
        if (i <= 30) a = ZW'(64'sd1 <<< (30 - i));
        else a = '0;
      end
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] clamp_one(input logic signed [XW-1:0] v);
    logic signed [31:0] r;
    if (v > XW'(ONE_Q30)) r = ONE_Q30;
    else if (v < -XW'(ONE_Q30)) r = -ONE_Q30;
    else r = v[31:0];
    return r;
  endfunction

  // Q30 product with rounding by adding half an LSB before the floor shift.
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = a * b;
    s = (p + 64'sd536870912) >>> 30;
    return s[31:0];
  endfunction

endpackage

/* design/great_circle_distance_top.sv */
// Great-circle distance between two points by the spherical law of cosines.
// Input stream: one word per point pair, s_axis_tdata holds lat_a, lon_a,
// lat_b and lon_b in units of 1e-7 degree. Output stream: one word per input
// word, m_axis_tdata holds the range in meters with 8 fraction bits,
// saturating at the top of its 33 bits.
// The user writes the sphere radius in whole meters through cfg_we_i/cfg_wdata_i
// only while no word is in flight, not enforced by the block. Reset loads 6371000.
// The datapath is a 106-stage pipeline: angle reduction and conversion to
// radians (6), a rotation CORDIC per angle (30), products and the clamp of the
// dot value (4), one stage for 1 - d^2, a bit-per-stage square root (32), a
// vectoring CORDIC for acos (30) and the radius scaling (3). One word is taken
// per cycle while the receiver does not stall.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all stage valid bits; payload registers are not reset.
module great_circle_distance_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gcd_pkg::RAD_W-1:0]   cfg_wdata_i,     // sphere radius in whole meters
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [gcd_pkg::DIN_W-1:0]   s_axis_tdata,    // lat_a, lon_a, lat_b, lon_b
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [gcd_pkg::DOUT_W-1:0]  m_axis_tdata     // range_q8
);
  import gcd_pkg::*;

  localparam int ST_D    = 6 + CORDIC_STEPS + 3;
  localparam int ST_SQRT = ST_D + 1 + SQRT_STEPS;
  localparam int ST_ACOS = PIPE_DEPTH - 3;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [RAD_W-1:0]      rad_q;

  assign en            = !vld_q[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rad_q <= RADIUS_RST;
    end else begin
      if (en) vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
      if (cfg_we_i) rad_q <= cfg_wdata_i;
    end
  end

  // Lane 0: lat_a, lane 1: lat_b, lane 2: lon_b - lon_a.
  logic signed [AW-1:0] ang0_q [0:2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang0_q[0] <= AW'($signed(s_axis_tdata[30:0]));
      ang0_q[1] <= AW'($signed(s_axis_tdata[93:63]));
      ang0_q[2] <= AW'($signed(s_axis_tdata[125:94])) - AW'($signed(s_axis_tdata[62:31]));
    end
  end

  logic signed [31:0] sin_q [0:1];
  logic signed [31:0] cos_q [0:2];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [AW-1:0] red_a, red_b;
    logic                 red_flip, red_neg;
    logic [AW-1:0]        red_mag;
    logic [29:0]          mag1_q;
    logic                 neg1_q, flip1_q;
    logic [61:0]          num2_q;
    logic                 neg2_q, flip2_q;
    logic [62:0]          qprod;
    logic [50:0]          nn3_q;
    logic [30:0]          qe3_q;
    logic                 neg3_q, flip3_q;
    logic [50:0]          nn4_q, qm4_q;
    logic [30:0]          qe4_q;
    logic                 neg4_q, flip4_q;
    logic [50:0]          rem_full;
    logic [22:0]          rem;
    logic [2:0]           corr;
    logic [30:0]          zq;
    logic signed [ZW-1:0] z5_q;
    logic                 flip5_q;
    logic signed [XW-1:0] rx_q [0:CORDIC_STEPS-1];
    logic signed [XW-1:0] ry_q [0:CORDIC_STEPS-1];
    logic signed [ZW-1:0] rz_q [0:CORDIC_STEPS-1];
    logic                 rf_q [0:CORDIC_STEPS-1];
    logic signed [XW-1:0] fx, fy;

    // Wrap into [-180, 180) degrees, then fold into [-90, 90] with a flip.
    always_comb begin
      if (ang0_q[l] >= HALF_E7) red_a = ang0_q[l] - TURN_E7;
      else if (ang0_q[l] < -HALF_E7) red_a = ang0_q[l] + TURN_E7;
      else red_a = ang0_q[l];
      red_flip = 1'b1;
      if (red_a > QUARTER_E7) red_b = red_a - HALF_E7;
      else if (red_a < -QUARTER_E7) red_b = red_a + HALF_E7;
      else begin
        red_b    = red_a;
        red_flip = 1'b0;
      end
      red_neg = red_b[AW-1];
      red_mag = red_neg ? AW'(-red_b) : AW'(red_b);
    end

    // The reciprocal estimate is low by at most four; the remainder fixes it.
    always_comb begin
      qprod    = 63'(num2_q[61:31]) * 63'(RECIP);
      rem_full = nn4_q - qm4_q;
      rem      = rem_full[22:0];
      priority if (rem >= DIVC4) corr = 3'd4;
      else if (rem >= DIVC3) corr = 3'd3;
      else if (rem >= DIVC2) corr = 3'd2;
      else if (rem >= DIVC1) corr = 3'd1;
      else corr = 3'd0;
      zq = qe4_q + 31'(corr);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        mag1_q  <= red_mag[29:0];
        neg1_q  <= red_neg;
        flip1_q <= red_flip;
        num2_q  <= 62'(mag1_q) * 62'(ZK) + ZBIAS;
        neg2_q  <= neg1_q;
        flip2_q <= flip1_q;
        nn3_q   <= num2_q[61:11];
        qe3_q   <= qprod[61:31];
        neg3_q  <= neg2_q;
        flip3_q <= flip2_q;
        nn4_q   <= nn3_q;
        qm4_q   <= 51'(qe3_q) * 51'(DIVC);
        qe4_q   <= qe3_q;
        neg4_q  <= neg3_q;
        flip4_q <= flip3_q;
        z5_q    <= neg4_q ? -$signed(ZW'(zq)) : $signed(ZW'(zq));
        flip5_q <= flip4_q;
      end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [XW-1:0] xi, yi;
      logic signed [ZW-1:0] zi;
      logic                 fi;
      if (i == 0) begin : g_first
        assign xi = GAIN_INV_Q30;
        assign yi = '0;
        assign zi = z5_q;
        assign fi = flip5_q;
      end else begin : g_next
        assign xi = rx_q[i-1];
        assign yi = ry_q[i-1];
        assign zi = rz_q[i-1];
        assign fi = rf_q[i-1];
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          if (zi >= 0) begin
            rx_q[i] <= xi - (yi >>> i);
            ry_q[i] <= yi + (xi >>> i);
            rz_q[i] <= zi - atan_q30(i);
          end else begin
            rx_q[i] <= xi + (yi >>> i);
            ry_q[i] <= yi - (xi >>> i);
            rz_q[i] <= zi + atan_q30(i);
          end
          rf_q[i] <= fi;
        end
      end
    end

    assign fx = rf_q[CORDIC_STEPS-1] ? -rx_q[CORDIC_STEPS-1] : rx_q[CORDIC_STEPS-1];
    assign fy = rf_q[CORDIC_STEPS-1] ? -ry_q[CORDIC_STEPS-1] : ry_q[CORDIC_STEPS-1];

    always_ff @(posedge clk_i) begin
      if (en) cos_q[l] <= clamp_one(fx);
    end

    if (l < 2) begin : g_sin
      always_ff @(posedge clk_i) begin
        if (en) sin_q[l] <= clamp_one(fy);
      end
    end else begin : g_nosin
      // The sine of the longitude difference does not enter the dot value.
      logic unused_sin;
      assign unused_sin = ^fy;
    end
  end

  // Dot value d = sa*sb + (ca*cb)*cd, then |d| and 1 - d^2.
  logic signed [31:0] p37_q, q37_q, cd37_q;
  logic signed [31:0] p38_q, r38_q;
  logic signed [32:0] dsum;
  logic signed [31:0] dcl;
  logic [30:0]        ad39_q, ad40_q;
  logic               dneg39_q, dneg40_q;
  logic [60:0]        n40_q;

  always_comb begin
    dsum = 33'(p38_q) + 33'(r38_q);
    if (dsum > 33'(ONE_Q30)) dcl = ONE_Q30;
    else if (dsum < -33'(ONE_Q30)) dcl = -ONE_Q30;
    else dcl = dsum[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p37_q    <= mul_q30(sin_q[0], sin_q[1]);
      q37_q    <= mul_q30(cos_q[0], cos_q[1]);
      cd37_q   <= cos_q[2];
      p38_q    <= p37_q;
      r38_q    <= mul_q30(q37_q, cd37_q);
      ad39_q   <= dcl[31] ? 31'(-dcl) : dcl[30:0];
      dneg39_q <= dcl[31];
      n40_q    <= ONE_SQ - 61'(62'(ad39_q) * 62'(ad39_q));
      ad40_q   <= ad39_q;
      dneg40_q <= dneg39_q;
    end
  end

  // Integer square root, one result bit per stage.
  logic [60:0] sn_q  [0:SQRT_STEPS-1];
  logic [61:0] sr_q  [0:SQRT_STEPS-1];
  logic [30:0] sad_q [0:SQRT_STEPS-1];
  logic        sdn_q [0:SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [60:0] ni;
    logic [61:0] ri;
    logic [30:0] ai;
    logic        di;
    logic [63:0] sbit, t, rn;
    if (k == 0) begin : g_first
      assign ni = n40_q;
      assign ri = '0;
      assign ai = ad40_q;
      assign di = dneg40_q;
    end else begin : g_next
      assign ni = sn_q[k-1];
      assign ri = sr_q[k-1];
      assign ai = sad_q[k-1];
      assign di = sdn_q[k-1];
    end
    assign sbit = 64'd1 << (62 - 2 * k);
    assign t    = 64'(ri) + sbit;
    assign rn   = (64'(ri) >> 1) + sbit;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (64'(ni) >= t) begin
          sn_q[k] <= ni - t[60:0];
          sr_q[k] <= rn[61:0];
        end else begin
          sn_q[k] <= ni;
          sr_q[k] <= ri >> 1;
        end
        sad_q[k] <= ai;
        sdn_q[k] <= di;
      end
    end
  end

  // Vectoring CORDIC: angle of (|d|, sqrt(1 - d^2)).
  logic signed [XW-1:0] vx_q [0:CORDIC_STEPS-1];
  logic signed [XW-1:0] vy_q [0:CORDIC_STEPS-1];
  logic signed [ZW-1:0] vz_q [0:CORDIC_STEPS-1];
  logic                 vd_q [0:CORDIC_STEPS-1];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    logic signed [XW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    logic                 di;
    if (i == 0) begin : g_first
      assign xi = $signed(XW'(sad_q[SQRT_STEPS-1]));
      assign yi = $signed(XW'(sr_q[SQRT_STEPS-1][30:0]));
      assign zi = '0;
      assign di = sdn_q[SQRT_STEPS-1];
    end else begin : g_next
      assign xi = vx_q[i-1];
      assign yi = vy_q[i-1];
      assign zi = vz_q[i-1];
      assign di = vd_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (yi >= 0) begin
          vx_q[i] <= xi + (yi >>> i);
          vy_q[i] <= yi - (xi >>> i);
          vz_q[i] <= zi + atan_q30(i);
        end else begin
          vx_q[i] <= xi - (yi >>> i);
          vy_q[i] <= yi + (xi >>> i);
          vz_q[i] <= zi - atan_q30(i);
        end
        vd_q[i] <= di;
      end
    end
  end

  // Clamp the angle to [0, pi], mirror for negative d, scale by the radius.
  logic signed [ZW-1:0] zc, zacos;
  logic [31:0]          acos_q;
  logic [54:0]          prod_q;
  logic [55:0]          rsum;
  logic [33:0]          rng;
  logic [RANGE_W-1:0]   out_q;

  always_comb begin
    if (vz_q[CORDIC_STEPS-1] < 0) zc = '0;
    else if (vz_q[CORDIC_STEPS-1] > PI_Q30) zc = PI_Q30;
    else zc = vz_q[CORDIC_STEPS-1];
    zacos = vd_q[CORDIC_STEPS-1] ? PI_Q30 - zc : zc;
    rsum  = 56'(prod_q) + 56'(64'd1 << 21);
    rng   = rsum[55:22];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acos_q <= zacos[31:0];
      prod_q <= 55'(rad_q) * 55'(acos_q);
      out_q  <= (rng > 34'(RANGE_MAX)) ? RANGE_MAX : rng[RANGE_W-1:0];
    end
  end

  assign m_axis_tdata = {{(DOUT_W - RANGE_W){1'b0}}, out_q};

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output stage is empty");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_dot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_D] |-> (ad39_q <= 31'(ONE_Q30)))
    else $error("clamped dot magnitude above one");

  a_sqrt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_SQRT] |-> (sr_q[SQRT_STEPS-1] <= 62'(ONE_Q30)))
    else $error("square root result above one");

  a_acos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_ACOS] |-> (acos_q <= 32'(PI_Q30)))
    else $error("central angle above pi");
`endif

endmodule
